/* hdl/cvs_pkg.sv */
// Shared constants and types of the cosine top-k vector search core.
package cvs_pkg;

    localparam int DIM_DEF       = 64;
    localparam int ENTRIES_DEF   = 256;
    localparam int LANES_DEF     = 4;
    localparam int MAX_TOP_K_DEF = 16;

    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 32;
    localparam int SCORE_W   = 16;
    localparam int IDX_OUT_W = 8;
    localparam int TOPK_IN_W = 5;
    localparam int IN_FIELDS = 4;
    localparam int FRAC_BITS = 15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NSWEEP,
        ST_NDRAIN,
        ST_SQRT,
        ST_DSWEEP,
        ST_DDRAIN,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_INS,
        ST_EMIT,
        ST_FULL
    } t_state;

    typedef struct packed {
        logic clear;
        logic insert;
        logic pop;
    } t_topk_ctl;

endpackage

/* hdl/cosine_topk_vector_search_core.sv */
// Top level of the cosine-similarity top-k vector search core.
// Vectors enter as groups of LANES Q1.15 elements, GROUPS = ceil(DIM/LANES) groups per vector.
// Groups before the last of a vector do not stall the input. The last group of an add
// then holds the input for a norm pass through the vector memory and the LANES multiply
// lanes and for the iterative square root, which yields a MAG_W-bit root (MAG_W is about
// half of 31 + log2(GROUPS*LANES)). The last group of a query takes the same norm pass on
// the query buffer, then, unless top_k is zero or the store is empty, scores every stored
// entry in turn: a dot product over the lanes and, when both norms are nonzero, the
// denominator multiply and the bit-serial divider, then a sorted insert. The ranked results
// then leave at one per cycle while the output side does not stall. An add to a full store
// answers with one status beat. No clearing pass runs after reset.
module cosine_topk_vector_search_core #(
    parameter int DIM       = cvs_pkg::DIM_DEF,
    parameter int ENTRIES   = cvs_pkg::ENTRIES_DEF,
    parameter int LANES     = cvs_pkg::LANES_DEF,
    parameter int MAX_TOP_K = cvs_pkg::MAX_TOP_K_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_command,
    input  logic signed [cvs_pkg::ELEM_W-1:0]     i_element_0,
    input  logic signed [cvs_pkg::ELEM_W-1:0]     i_element_1,
    input  logic signed [cvs_pkg::ELEM_W-1:0]     i_element_2,
    input  logic signed [cvs_pkg::ELEM_W-1:0]     i_element_3,
    input  logic                                  i_last_group,
    input  logic [cvs_pkg::TOPK_IN_W-1:0]         i_top_k,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [cvs_pkg::IDX_OUT_W-1:0]         o_entry_index,
    output logic signed [cvs_pkg::SCORE_W-1:0]    o_score,
    output logic                                  o_status,
    output logic                                  o_last
);

    localparam int EL_W    = cvs_pkg::ELEM_W;
    localparam int PW      = cvs_pkg::PROD_W;
    localparam int SW      = cvs_pkg::SCORE_W;
    localparam int IOW     = cvs_pkg::IDX_OUT_W;
    localparam int GROUPS  = (DIM + LANES - 1) / LANES;
    localparam int GW      = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int VLEN    = GROUPS * LANES;
    localparam int NW0     = 31 + $clog2(VLEN);
    localparam int NORM_W  = NW0 + (NW0 % 2);
    localparam int MAG_W   = NORM_W / 2;
    localparam int ACC_W   = NORM_W + 1;
    localparam int EW      = $clog2(ENTRIES);
    localparam int CW      = $clog2(ENTRIES + 1);
    localparam int KW      = $clog2(MAX_TOP_K + 1);
    localparam int MEM_W   = LANES * EL_W;
    localparam int QDEPTH  = 1 << GW;
    localparam int VDEPTH  = ENTRIES * QDEPTH;

    cvs_pkg::t_state    r_state, n_state;
    cvs_pkg::t_topk_ctl w_tk_ctl;

    logic [GW-1:0]   r_gpos;
    logic [GW-1:0]   r_pos;
    logic [CW-1:0]   r_count;
    logic            r_is_query;
    logic [KW-1:0]   r_k;
    logic [GW:0]     r_sw;
    logic [EW-1:0]   r_scan_e;
    logic [MAG_W-1:0] r_qmag;

    logic [MEM_W-1:0] vmem [VDEPTH];
    logic [MEM_W-1:0] qmem [QDEPTH];
    logic [MAG_W-1:0] magmem [ENTRIES];
    logic [MEM_W-1:0] r_vq;
    logic [MEM_W-1:0] r_qq;
    logic [MAG_W-1:0] r_mag_q;

    logic             r_s1;
    logic             r_s1_zero;
    logic             r_s1_dot;
    logic signed [ACC_W-1:0]  r_acc;
    logic [NORM_W-1:0]        r_den;
    logic signed [SW-1:0]     r_score;

    logic                     r_o_valid;
    logic [IOW-1:0]           r_o_idx;
    logic signed [SW-1:0]     r_o_score;
    logic                     r_o_status;
    logic                     r_o_last;

    logic signed [EL_W-1:0]   w_el [cvs_pkg::IN_FIELDS];
    logic [MEM_W-1:0]         w_lanes;
    logic signed [EL_W-1:0]   w_a [LANES];
    logic signed [EL_W-1:0]   w_b [LANES];
    logic signed [PW-1:0]     w_prod [LANES];
    logic [LANES-1:0]         w_lane_v;
    logic signed [ACC_W-1:0]  w_sum;

    logic             w_accept;
    logic             w_full;
    logic             w_issue;
    logic [GW-1:0]    w_p;
    logic             w_zero_p;
    logic             w_empty;
    logic             w_out_free;
    logic             w_acc_clr;
    logic             w_sq_start;
    logic             w_dv_start;
    logic             w_load_rank;
    logic             w_load_full;
    logic             w_score_zero;
    logic             w_v_we;
    logic [EW+GW-1:0] w_v_waddr;
    logic [EW+GW-1:0] w_v_raddr;
    logic             w_q_we;
    logic [GW-1:0]    w_q_waddr;
    logic             w_sq_done;
    logic [MAG_W-1:0] w_root;
    logic             w_dv_done;
    logic signed [SW-1:0] w_dv_q;
    logic [KW-1:0]    w_tk_cnt;
    logic signed [SW-1:0] w_tk_score;
    logic [EW-1:0]    w_tk_idx;

    assign w_el[0] = i_element_0;
    assign w_el[1] = i_element_1;
    assign w_el[2] = i_element_2;
    assign w_el[3] = i_element_3;

    for (genvar j = 0; j < LANES; j++) begin : g_pack
        if (j < cvs_pkg::IN_FIELDS) begin : g_in
            assign w_lanes[j*EL_W +: EL_W] = w_el[j];
        end else begin : g_pad
            assign w_lanes[j*EL_W +: EL_W] = '0;
        end
    end

    assign o_in_stall = (r_state != cvs_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == cvs_pkg::ST_IDLE);
    assign w_full     = r_count >= CW'(ENTRIES);
    assign w_issue    = (r_state == cvs_pkg::ST_NSWEEP) || (r_state == cvs_pkg::ST_DSWEEP);
    assign w_p        = r_sw[GW-1:0];
    assign w_zero_p   = (r_state == cvs_pkg::ST_NSWEEP) && (w_p > r_pos);
    assign w_empty    = !r_s1 && !w_lane_v[0];
    assign w_out_free = !r_o_valid || !i_out_stall;

    // Memory ports: input beats write the current group, the norm pass zeroes the tail.
    always_comb begin
        w_v_we    = (w_accept && !i_command && !w_full)
                 || (w_zero_p && !r_is_query);
        w_v_waddr = w_accept ? {r_count[EW-1:0], r_gpos} : {r_count[EW-1:0], w_p};
        w_q_we    = (w_accept && i_command) || (w_zero_p && r_is_query);
        w_q_waddr = w_accept ? r_gpos : w_p;
        w_v_raddr = (r_state == cvs_pkg::ST_DSWEEP) ? {r_scan_e, w_p}
                                                    : {r_count[EW-1:0], w_p};
    end

    always_ff @(posedge i_clk) begin
        if (w_v_we) begin
            vmem[w_v_waddr] <= w_accept ? w_lanes : '0;
        end
        r_vq <= vmem[w_v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            qmem[w_q_waddr] <= w_accept ? w_lanes : '0;
        end
        r_qq <= qmem[w_p];
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == cvs_pkg::ST_SQRT) && w_sq_done && !r_is_query) begin
            magmem[r_count[EW-1:0]] <= w_root;
        end
        r_mag_q <= magmem[r_scan_e];
    end

    // Lane operands: squares in the norm pass, entry times query in the scoring pass.
    always_comb begin
        for (int j = 0; j < LANES; j++) begin
            if (r_s1_zero) begin
                w_a[j] = '0;
                w_b[j] = '0;
            end else if (r_s1_dot) begin
                w_a[j] = r_vq[j*EL_W +: EL_W];
                w_b[j] = r_qq[j*EL_W +: EL_W];
            end else if (r_is_query) begin
                w_a[j] = r_qq[j*EL_W +: EL_W];
                w_b[j] = r_qq[j*EL_W +: EL_W];
            end else begin
                w_a[j] = r_vq[j*EL_W +: EL_W];
                w_b[j] = r_vq[j*EL_W +: EL_W];
            end
        end
    end

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        cvs_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_s1),
            .i_a     (w_a[j]),
            .i_b     (w_b[j]),
            .o_valid (w_lane_v[j]),
            .o_prod  (w_prod[j])
        );
    end

    always_comb begin
        w_sum = '0;
        for (int j = 0; j < LANES; j++) begin
            w_sum = w_sum + ACC_W'(w_prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= 1'b0;
        end else begin
            r_s1 <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_zero <= w_zero_p;
        r_s1_dot  <= (r_state == cvs_pkg::ST_DSWEEP);
        if (w_acc_clr) begin
            r_acc <= '0;
        end else if (w_lane_v[0]) begin
            r_acc <= r_acc + w_sum;
        end
    end

    cvs_isqrt #(
        .NORM_W (NORM_W),
        .MAG_W  (MAG_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_n     (r_acc[NORM_W-1:0]),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    cvs_div #(
        .NORM_W (NORM_W),
        .ACC_W  (ACC_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dv_start),
        .i_dot   (r_acc),
        .i_den   (r_den),
        .o_done  (w_dv_done),
        .o_q     (w_dv_q)
    );

    cvs_topk #(
        .MAX_TOP_K (MAX_TOP_K),
        .IDX_W     (EW),
        .KW        (KW)
    ) u_topk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_tk_ctl),
        .i_k          (r_k),
        .i_score      (r_score),
        .i_idx        (r_scan_e),
        .o_cnt        (w_tk_cnt),
        .o_head_score (w_tk_score),
        .o_head_idx   (w_tk_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cvs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        w_acc_clr    = 1'b0;
        w_sq_start   = 1'b0;
        w_dv_start   = 1'b0;
        w_load_rank  = 1'b0;
        w_load_full  = 1'b0;
        w_score_zero = 1'b0;
        w_tk_ctl     = '0;
        unique case (r_state)
            cvs_pkg::ST_IDLE: begin
                if (w_accept && i_last_group) begin
                    if (!i_command && w_full) begin
                        n_state = cvs_pkg::ST_FULL;
                    end else begin
                        n_state   = cvs_pkg::ST_NSWEEP;
                        w_acc_clr = 1'b1;
                    end
                end
            end
            cvs_pkg::ST_NSWEEP: begin
                if (r_sw == (GW+1)'(GROUPS - 1)) begin
                    n_state = cvs_pkg::ST_NDRAIN;
                end
            end
            cvs_pkg::ST_NDRAIN: begin
                if (w_empty) begin
                    w_sq_start = 1'b1;
                    n_state    = cvs_pkg::ST_SQRT;
                end
            end
            cvs_pkg::ST_SQRT: begin
                if (w_sq_done) begin
                    if (!r_is_query || (r_k == '0) || (r_count == '0)) begin
                        n_state = cvs_pkg::ST_IDLE;
                    end else begin
                        w_tk_ctl.clear = 1'b1;
                        w_acc_clr      = 1'b1;
                        n_state        = cvs_pkg::ST_DSWEEP;
                    end
                end
            end
            cvs_pkg::ST_DSWEEP: begin
                if (r_sw == (GW+1)'(GROUPS - 1)) begin
                    n_state = cvs_pkg::ST_DDRAIN;
                end
            end
            cvs_pkg::ST_DDRAIN: begin
                if (w_empty) begin
                    if ((r_mag_q == '0) || (r_qmag == '0)) begin
                        w_score_zero = 1'b1;
                        n_state      = cvs_pkg::ST_INS;
                    end else begin
                        n_state = cvs_pkg::ST_MUL;
                    end
                end
            end
            cvs_pkg::ST_MUL: begin
                n_state = cvs_pkg::ST_DSTART;
            end
            cvs_pkg::ST_DSTART: begin
                w_dv_start = 1'b1;
                n_state    = cvs_pkg::ST_DIV;
            end
            cvs_pkg::ST_DIV: begin
                if (w_dv_done) begin
                    n_state = cvs_pkg::ST_INS;
                end
            end
            cvs_pkg::ST_INS: begin
                w_tk_ctl.insert = 1'b1;
                if ((CW'(r_scan_e) + CW'(1)) == r_count) begin
                    n_state = cvs_pkg::ST_EMIT;
                end else begin
                    w_acc_clr = 1'b1;
                    n_state   = cvs_pkg::ST_DSWEEP;
                end
            end
            cvs_pkg::ST_EMIT: begin
                if (w_tk_cnt == '0) begin
                    n_state = cvs_pkg::ST_IDLE;
                end else if (w_out_free) begin
                    w_load_rank  = 1'b1;
                    w_tk_ctl.pop = 1'b1;
                    if (w_tk_cnt == KW'(1)) begin
                        n_state = cvs_pkg::ST_IDLE;
                    end
                end
            end
            cvs_pkg::ST_FULL: begin
                if (w_out_free) begin
                    w_load_full = 1'b1;
                    n_state     = cvs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cvs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gpos  <= '0;
            r_count <= '0;
            r_qmag  <= '0;
        end else begin
            if (w_accept) begin
                if (i_last_group) begin
                    r_gpos <= '0;
                end else if (r_gpos != GW'(GROUPS - 1)) begin
                    r_gpos <= r_gpos + GW'(1);
                end
            end
            if ((r_state == cvs_pkg::ST_SQRT) && w_sq_done) begin
                if (r_is_query) begin
                    r_qmag <= w_root;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos      <= r_gpos;
            r_is_query <= i_command;
            if (i_command && i_last_group) begin
                r_k <= (32'(i_top_k) > MAX_TOP_K) ? KW'(MAX_TOP_K) : KW'(i_top_k);
            end
        end
        if (w_acc_clr) begin
            r_sw <= '0;
        end else if (w_issue) begin
            r_sw <= r_sw + (GW+1)'(1);
        end
        if (w_tk_ctl.clear) begin
            r_scan_e <= '0;
        end else if ((r_state == cvs_pkg::ST_INS) && (n_state == cvs_pkg::ST_DSWEEP)) begin
            r_scan_e <= r_scan_e + EW'(1);
        end
        if (r_state == cvs_pkg::ST_MUL) begin
            r_den <= r_mag_q * r_qmag;
        end
        if (w_score_zero) begin
            r_score <= '0;
        end else if ((r_state == cvs_pkg::ST_DIV) && w_dv_done) begin
            r_score <= w_dv_q;
        end
    end

    // Output register: load a new beat when empty or when the current beat leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load_rank || w_load_full) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_rank) begin
            r_o_idx    <= IOW'(w_tk_idx);
            r_o_score  <= w_tk_score;
            r_o_status <= 1'b0;
            r_o_last   <= (w_tk_cnt == KW'(1));
        end else if (w_load_full) begin
            r_o_idx    <= '0;
            r_o_score  <= '0;
            r_o_status <= 1'b1;
            r_o_last   <= 1'b1;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_entry_index = r_o_idx;
    assign o_score       = r_o_score;
    assign o_status      = r_o_status;
    assign o_last        = r_o_last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("entry count beyond store depth");
    a_sqrt_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_done |-> (r_state == cvs_pkg::ST_SQRT))
        else $error("square root finished outside its wait state");
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_done |-> (r_state == cvs_pkg::ST_DIV))
        else $error("divider finished outside its wait state");
    a_topk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tk_cnt <= r_k)
        else $error("best list holds more than top_k entries");
`endif

endmodule

/* hdl/cvs_lane.sv */
// One multiply lane: registered signed product of two Q1.15 elements.
module cvs_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [cvs_pkg::ELEM_W-1:0]   i_a,
    input  logic signed [cvs_pkg::ELEM_W-1:0]   i_b,
    output logic                                o_valid,
    output logic signed [cvs_pkg::PROD_W-1:0]   o_prod
);

    logic                              r_valid;
    logic signed [cvs_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

/* hdl/cvs_isqrt.sv */
// Iterative integer square root, two radicand bits per cycle.
module cvs_isqrt #(
    parameter int NORM_W = 38,
    parameter int MAG_W  = 19
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NORM_W-1:0] i_n,
    output logic              o_done,
    output logic [MAG_W-1:0]  o_root
);

    logic              r_busy;
    logic              r_done;
    logic [NORM_W-1:0] r_rem;
    logic [NORM_W-1:0] r_res;
    logic [NORM_W-1:0] r_bit;
    logic [NORM_W:0]   w_trial;
    logic              w_take;

    assign w_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign w_take  = {1'b0, r_rem} >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_bit[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_n;
            r_res <= '0;
            r_bit <= NORM_W'(1) << (NORM_W - 2);
        end else if (r_busy) begin
            if (w_take) begin
                r_rem <= r_rem - w_trial[NORM_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[MAG_W-1:0];

endmodule

/* hdl/cvs_div.sv */
// Restoring divider: saturated Q1.15 quotient of dot * 2^15 / denominator.
module cvs_div #(
    parameter int NORM_W = 38,
    parameter int ACC_W  = 39
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [ACC_W-1:0]              i_dot,
    input  logic [NORM_W-1:0]                    i_den,
    output logic                                 o_done,
    output logic signed [cvs_pkg::SCORE_W-1:0]   o_q
);

    localparam int QB = cvs_pkg::FRAC_BITS;
    localparam int CNT_W = $clog2(QB + 1);
    localparam int SW = cvs_pkg::SCORE_W;

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic              r_sat;
    logic [CNT_W-1:0]  r_cnt;
    logic [NORM_W-1:0] r_rem;
    logic [NORM_W-1:0] r_den;
    logic [QB-1:0]     r_q;
    logic [ACC_W-1:0]  w_abs;
    logic [NORM_W-1:0] w_a;
    logic [NORM_W:0]   w_sh;
    logic              w_fit;
    logic              w_last;

    assign w_abs  = i_dot[ACC_W-1] ? ACC_W'(-i_dot) : ACC_W'(i_dot);
    assign w_a    = w_abs[NORM_W-1:0];
    assign w_sh   = {r_rem, 1'b0};
    assign w_fit  = w_sh >= {1'b0, r_den};
    assign w_last = r_sat || (r_cnt == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dot[ACC_W-1];
            r_sat <= w_a >= i_den;
            r_rem <= w_a;
            r_den <= i_den;
            r_q   <= '0;
            r_cnt <= CNT_W'(QB);
        end else if (r_busy && !r_sat) begin
            if (w_fit) begin
                r_rem <= w_sh[NORM_W-1:0] - r_den;
            end else begin
                r_rem <= w_sh[NORM_W-1:0];
            end
            r_q   <= {r_q[QB-2:0], w_fit};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_comb begin
        if (r_sat) begin
            o_q = r_neg ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else if (r_neg) begin
            o_q = -$signed({1'b0, r_q});
        end else begin
            o_q = $signed({1'b0, r_q});
        end
    end

    assign o_done = r_done;

endmodule

/* hdl/cvs_topk.sv */
// Sorted best list: parallel insert by score, ties kept at the lower index, pop from head.
module cvs_topk #(
    parameter int MAX_TOP_K = 16,
    parameter int IDX_W     = 8,
    parameter int KW        = 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  cvs_pkg::t_topk_ctl                 i_ctl,
    input  logic [KW-1:0]                      i_k,
    input  logic signed [cvs_pkg::SCORE_W-1:0] i_score,
    input  logic [IDX_W-1:0]                   i_idx,
    output logic [KW-1:0]                      o_cnt,
    output logic signed [cvs_pkg::SCORE_W-1:0] o_head_score,
    output logic [IDX_W-1:0]                   o_head_idx
);

    logic signed [cvs_pkg::SCORE_W-1:0] r_sc [MAX_TOP_K];
    logic [IDX_W-1:0]                   r_ix [MAX_TOP_K];
    logic [KW-1:0]                      r_cnt;
    logic [MAX_TOP_K-1:0]               w_ge;
    logic [MAX_TOP_K-1:0]               w_room;
    logic                               w_take;

    always_comb begin
        for (int i = 0; i < MAX_TOP_K; i++) begin
            w_ge[i]   = (i < int'(r_cnt)) && (r_sc[i] >= i_score);
            w_room[i] = (i < int'(i_k)) && !w_ge[i];
        end
        w_take = |w_room;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.clear) begin
            r_cnt <= '0;
        end else if (i_ctl.insert && w_take && (r_cnt < i_k)) begin
            r_cnt <= r_cnt + KW'(1);
        end else if (i_ctl.pop && (r_cnt != '0)) begin
            r_cnt <= r_cnt - KW'(1);
        end
    end

    // Slots below the insert point hold, the new entry lands there, the rest move down.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_TOP_K; i++) begin
            if (i_ctl.insert && w_take) begin
                if (!w_ge[i]) begin
                    if (i == 0) begin
                        r_sc[i] <= i_score;
                        r_ix[i] <= i_idx;
                    end else if (w_ge[i-1]) begin
                        r_sc[i] <= i_score;
                        r_ix[i] <= i_idx;
                    end else begin
                        r_sc[i] <= r_sc[i-1];
                        r_ix[i] <= r_ix[i-1];
                    end
                end
            end else if (i_ctl.pop && (i < MAX_TOP_K - 1)) begin
                r_sc[i] <= r_sc[i+1];
                r_ix[i] <= r_ix[i+1];
            end
        end
    end

    assign o_cnt        = r_cnt;
    assign o_head_score = r_sc[0];
    assign o_head_idx   = r_ix[0];

endmodule
